@@ rtl/core/slp_pkg.sv @@
// Shared types, constants and helpers for the SIZE line parser and capture control.
package slp_pkg;

	// Default line buffer capacity in characters (line ends at capacity minus one).
	localparam int LINE_CAPACITY_DEF = 64;

	// Register reset value and value limits.
	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [15:0] MAG_MAX = 16'd32767;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;
	localparam logic [15:0] STORE_NONE = 16'hFFFF;

	// Characters of interest.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	// Event kind of one input beat.
	typedef enum logic [1:0] {
		MODE_BYTE = 2'd0,
		MODE_TICK = 2'd1,
		MODE_REQ = 2'd2,
		MODE_POP = 2'd3
	} mode_t;

	// Line matcher phase.
	typedef enum logic [3:0] {
		PH_S = 4'd0,
		PH_I = 4'd1,
		PH_Z = 4'd2,
		PH_E = 4'd3,
		PH_WS1 = 4'd4,
		PH_SIGN1 = 4'd5,
		PH_DIG1 = 4'd6,
		PH_WS2 = 4'd7,
		PH_SIGN2 = 4'd8,
		PH_DIG2 = 4'd9,
		PH_DONE = 4'd10,
		PH_FAIL = 4'd11
	} phase_t;

	// Capture handshake state; encoding equals the reported status.
	typedef enum logic [1:0] {
		CAP_IDLE = 2'd0,
		CAP_PENDING = 2'd1,
		CAP_READY = 2'd2,
		CAP_TIMEOUT = 2'd3
	} cap_state_t;

	// Parser result for the beat being processed.
	typedef struct packed {
		logic commit;
		logic [15:0] median;
		logic [15:0] iqr;
	} parse_res_t;

	// Capture control result for the beat being processed.
	typedef struct packed {
		cap_state_t status;
		logic accepted;
		logic popped;
	} cap_res_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	// value * 10 + digit, saturated at MAG_MAX
	function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [7:0] c);
		logic [18:0] t;
		t = {v, 3'b000} + {2'b00, v, 1'b0} + {15'd0, c[3:0]};
		return (t > {3'b000, MAG_MAX}) ? MAG_MAX : t[15:0];
	endfunction

endpackage

@@ rtl/core/slp_parser.sv @@
// Per-byte SIZE line matcher with stored median / IQR pair.
module slp_parser #(
	parameter int LINE_CAPACITY = slp_pkg::LINE_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  slp_pkg::mode_t mode,
	input  logic [7:0] rx_byte,
	output slp_pkg::parse_res_t res
);

	localparam int LEN_W = $clog2(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

	slp_pkg::phase_t phase_q, phase_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic neg_q, neg_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] first_q, first_d;
	logic first_neg_q, first_neg_d;
	logic [15:0] median_q, median_d;
	logic [15:0] iqr_q, iqr_d;
	logic commit;
	logic [15:0] acc_c;

	assign acc_c = slp_pkg::acc_digit(acc_q, rx_byte);

	// Advance the matcher by one character, or close the line
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		neg_d = neg_q;
		acc_d = acc_q;
		first_d = first_q;
		first_neg_d = first_neg_q;
		median_d = median_q;
		iqr_d = iqr_q;
		commit = 1'b0;
		if (step && mode == slp_pkg::MODE_BYTE && rx_byte != slp_pkg::CH_CR) begin
			if (rx_byte == slp_pkg::CH_LF || len_q >= LEN_LAST) begin
				// End of line: commit a well-formed pair, then clear the line
				if ((phase_q == slp_pkg::PH_DIG2 || phase_q == slp_pkg::PH_DONE) &&
						!first_neg_q && first_q != 16'd0 && (!neg_q || acc_q == 16'd0)) begin
					commit = 1'b1;
					median_d = first_q;
					iqr_d = acc_q;
				end
				phase_d = slp_pkg::PH_S;
				len_d = '0;
				neg_d = 1'b0;
				acc_d = '0;
				first_d = '0;
				first_neg_d = 1'b0;
			end else begin
				len_d = len_q + LEN_W'(1);
				unique case (phase_q)
					slp_pkg::PH_S: begin
						phase_d = (rx_byte == slp_pkg::CH_S) ? slp_pkg::PH_I : slp_pkg::PH_FAIL;
					end
					slp_pkg::PH_I: begin
						phase_d = (rx_byte == slp_pkg::CH_I) ? slp_pkg::PH_Z : slp_pkg::PH_FAIL;
					end
					slp_pkg::PH_Z: begin
						phase_d = (rx_byte == slp_pkg::CH_Z) ? slp_pkg::PH_E : slp_pkg::PH_FAIL;
					end
					slp_pkg::PH_E: begin
						phase_d = (rx_byte == slp_pkg::CH_E) ? slp_pkg::PH_WS1 : slp_pkg::PH_FAIL;
					end
					slp_pkg::PH_WS1: begin
						priority if (slp_pkg::is_space(rx_byte)) begin
							phase_d = slp_pkg::PH_WS1;
						end else if (slp_pkg::is_sign(rx_byte)) begin
							neg_d = (rx_byte == slp_pkg::CH_MINUS);
							phase_d = slp_pkg::PH_SIGN1;
						end else if (slp_pkg::is_digit(rx_byte)) begin
							acc_d = acc_c;
							phase_d = slp_pkg::PH_DIG1;
						end else begin
							phase_d = slp_pkg::PH_FAIL;
						end
					end
					slp_pkg::PH_SIGN1, slp_pkg::PH_SIGN2: begin
						if (slp_pkg::is_digit(rx_byte)) begin
							acc_d = acc_c;
							phase_d = (phase_q == slp_pkg::PH_SIGN1) ?
								slp_pkg::PH_DIG1 : slp_pkg::PH_DIG2;
						end else begin
							phase_d = slp_pkg::PH_FAIL;
						end
					end
					slp_pkg::PH_DIG1, slp_pkg::PH_WS2: begin
						if (phase_q == slp_pkg::PH_DIG1 && slp_pkg::is_digit(rx_byte)) begin
							acc_d = acc_c;
						end else begin
							// Start (or wait for) the second number
							if (phase_q == slp_pkg::PH_DIG1) begin
								first_d = acc_q;
								first_neg_d = neg_q;
								neg_d = 1'b0;
							end
							priority if (slp_pkg::is_space(rx_byte)) begin
								acc_d = '0;
								phase_d = slp_pkg::PH_WS2;
							end else if (slp_pkg::is_sign(rx_byte)) begin
								acc_d = '0;
								neg_d = (rx_byte == slp_pkg::CH_MINUS);
								phase_d = slp_pkg::PH_SIGN2;
							end else if (slp_pkg::is_digit(rx_byte)) begin
								acc_d = {12'd0, rx_byte[3:0]};
								phase_d = slp_pkg::PH_DIG2;
							end else begin
								acc_d = '0;
								phase_d = slp_pkg::PH_FAIL;
							end
						end
					end
					slp_pkg::PH_DIG2: begin
						if (slp_pkg::is_digit(rx_byte)) begin
							acc_d = acc_c;
						end else begin
							phase_d = slp_pkg::PH_DONE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// Hold matcher state and stored pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slp_pkg::PH_S;
			len_q <= '0;
			neg_q <= 1'b0;
			acc_q <= '0;
			first_q <= '0;
			first_neg_q <= 1'b0;
			median_q <= slp_pkg::STORE_NONE;
			iqr_q <= slp_pkg::STORE_NONE;
		end else begin
			phase_q <= phase_d;
			len_q <= len_d;
			neg_q <= neg_d;
			acc_q <= acc_d;
			first_q <= first_d;
			first_neg_q <= first_neg_d;
			median_q <= median_d;
			iqr_q <= iqr_d;
		end
	end

	assign res.commit = commit;
	assign res.median = median_d;
	assign res.iqr = iqr_d;

endmodule

@@ rtl/core/slp_capture.sv @@
// Capture request state machine with millisecond timeout.
module slp_capture (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  slp_pkg::mode_t mode,
	input  logic commit,
	input  logic [15:0] timeout_ticks,
	output slp_pkg::cap_res_t res
);

	slp_pkg::cap_state_t state_q, state_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic accepted, popped;

	// Next state, elapsed count and per-beat flags
	always_comb begin
		state_d = state_q;
		elapsed_d = elapsed_q;
		accepted = 1'b0;
		popped = 1'b0;
		if (step) begin
			unique case (mode)
				slp_pkg::MODE_BYTE: begin
					if (commit && state_q == slp_pkg::CAP_PENDING) begin
						state_d = slp_pkg::CAP_READY;
					end
				end
				slp_pkg::MODE_TICK: begin
					if (elapsed_q != slp_pkg::TICK_MAX) begin
						elapsed_d = elapsed_q + 16'd1;
					end
					if (state_q == slp_pkg::CAP_PENDING && elapsed_d >= timeout_ticks) begin
						state_d = slp_pkg::CAP_TIMEOUT;
					end
				end
				slp_pkg::MODE_REQ: begin
					if (state_q != slp_pkg::CAP_PENDING) begin
						state_d = slp_pkg::CAP_PENDING;
						elapsed_d = '0;
						accepted = 1'b1;
					end
				end
				slp_pkg::MODE_POP: begin
					if (state_q == slp_pkg::CAP_READY) begin
						state_d = slp_pkg::CAP_IDLE;
						popped = 1'b1;
					end else if (state_q == slp_pkg::CAP_TIMEOUT) begin
						state_d = slp_pkg::CAP_IDLE;
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	// Hold state and tick count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slp_pkg::CAP_IDLE;
			elapsed_q <= '0;
		end else begin
			state_q <= state_d;
			elapsed_q <= elapsed_d;
		end
	end

	assign res.status = state_d;
	assign res.accepted = accepted;
	assign res.popped = popped;

endmodule

@@ rtl/core/size_line_parser_capture_ctl.sv @@
// Top level: SIZE line parser and capture control with input and result registers.
//
// Input channel (in_valid/in_ready) carries one event per beat: mode selects a
// received byte (rx_byte), a millisecond tick, a capture request or a result pop.
// Output channel (out_valid/out_ready) returns exactly one result beat per input
// beat: the stored median/IQR pair, the capture status after the event, and the
// per-beat flags measurement_updated, request_accepted, send_capture, pop_valid.
// Write the timeout register (cfg_we/cfg_wdata) only while idle; no check in block.
//
// A beat passes through the input register, then the parser and capture logic
// update their state and load the result register. Throughput is one beat per
// cycle while out_ready is high; the parser and capture state are both updated
// in a single pass from the input register.
// When out_ready is low the result register holds, the input register keeps its
// beat, and in_ready drops once both are full; no beat is lost or repeated.
// Reset (arst_n low) empties both registers, clears the line matcher, sets the
// stored pair to -1, the capture state to idle and timeout_ticks to 5000.
module size_line_parser_capture_ctl #(
	parameter int LINE_CAPACITY = slp_pkg::LINE_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] rx_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] median_size,
	output logic signed [15:0] iqr_um,
	output logic [1:0] capture_status,
	output logic measurement_updated,
	output logic request_accepted,
	output logic send_capture,
	output logic pop_valid
);

	logic [15:0] timeout_q;
	logic valid_s1;
	slp_pkg::mode_t mode_s1;
	logic [7:0] byte_s1;
	logic advance;
	logic valid_s2;
	logic [15:0] median_s2, iqr_s2;
	slp_pkg::cap_state_t status_s2;
	logic updated_s2, accepted_s2, popped_s2;
	slp_pkg::parse_res_t parse_res;
	slp_pkg::cap_res_t cap_res;

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= slp_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Move a beat from the input register to the result register
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= slp_pkg::mode_t'(mode);
			byte_s1 <= rx_byte;
		end
	end

	slp_parser #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.mode(mode_s1),
		.rx_byte(byte_s1),
		.res(parse_res)
	);

	slp_capture u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.mode(mode_s1),
		.commit(parse_res.commit),
		.timeout_ticks(timeout_q),
		.res(cap_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			median_s2 <= parse_res.median;
			iqr_s2 <= parse_res.iqr;
			status_s2 <= cap_res.status;
			updated_s2 <= parse_res.commit;
			accepted_s2 <= cap_res.accepted;
			popped_s2 <= cap_res.popped;
		end
	end

	assign out_valid = valid_s2;
	assign median_size = median_s2;
	assign iqr_um = iqr_s2;
	assign capture_status = status_s2;
	assign measurement_updated = updated_s2;
	assign request_accepted = accepted_s2;
	assign send_capture = accepted_s2;
	assign pop_valid = popped_s2;

endmodule
